FILE: hw/rtl/prd_pkg.sv
`default_nettype none

package prd_pkg;

  // input and register field widths
  localparam int COORD_BITS = 12;
  localparam int SUB_BITS   = 4;
  localparam int FRAC_BITS  = 16;
  localparam int DIM_BITS   = 13;
  localparam int CW         = FRAC_BITS + 2;
  localparam int VEC_W      = 3 * CW;
  localparam int TAN_W      = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 3;

  // normalized vectors keep their largest magnitude at or below this bit
  localparam int NORM_BIT   = 30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_TAN    = 3'd2,
    REG_RIGHT  = 3'd3,
    REG_UP     = 3'd4,
    REG_FRONT  = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prd_div.sv
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
// the caller guarantees the quotient fits in Q_W bits
module prd_div #(
  parameter int N_W = 34,
  parameter int D_W = 16,
  parameter int Q_W = 30,
  parameter int S_W = 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [N_W-1:0] in_num,
  input  wire logic [D_W-1:0] in_den,
  input  wire logic [S_W-1:0] in_side,
  output logic                out_valid,
  output logic [Q_W-1:0]      out_quo,
  output logic [S_W-1:0]      out_side
);

  logic           vld_r  [Q_W];
  logic [D_W-1:0] rem_r  [Q_W];
  logic [D_W-1:0] den_r  [Q_W];
  logic [Q_W-1:0] quo_r  [Q_W];
  logic [Q_W-1:0] low_r  [Q_W];
  logic [S_W-1:0] side_r [Q_W];

  logic           vld_nxt  [Q_W];
  logic [D_W-1:0] rem_nxt  [Q_W];
  logic [D_W-1:0] den_nxt  [Q_W];
  logic [Q_W-1:0] quo_nxt  [Q_W];
  logic [Q_W-1:0] low_nxt  [Q_W];
  logic [S_W-1:0] side_nxt [Q_W];

  // one compare and subtract per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic           vld_in;
    logic [D_W-1:0] rem_in;
    logic [D_W-1:0] den_in;
    logic [Q_W-1:0] quo_in;
    logic [Q_W-1:0] low_in;
    logic [S_W-1:0] side_in;
    logic [D_W:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = D_W'(in_num[N_W-1:Q_W]);
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign low_in  = in_num[Q_W-1:0];
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign low_in  = low_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial       = {rem_in, low_in[Q_W-1]};
    assign ge          = (trial >= {1'b0, den_in});
    assign vld_nxt[k]  = vld_in;
    assign rem_nxt[k]  = ge ? D_W'(trial - {1'b0, den_in}) : trial[D_W-1:0];
    assign den_nxt[k]  = den_in;
    assign quo_nxt[k]  = {quo_in[Q_W-2:0], ge};
    assign low_nxt[k]  = {low_in[Q_W-2:0], 1'b0};
    assign side_nxt[k] = side_in;
  end

  // valid bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        low_r[k]  <= low_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/prd_sqrt.sv
`default_nettype none

// pipelined integer square root, one root bit per stage, floor result
module prd_sqrt #(
  parameter int N_W = 62,
  parameter int S_W = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [N_W-1:0]   in_rad,
  input  wire logic [S_W-1:0]   in_side,
  output logic                  out_valid,
  output logic [N_W/2-1:0]      out_root,
  output logic [S_W-1:0]        out_side
);

  localparam int R_W   = N_W / 2;
  localparam int REM_W = R_W + 2;
  localparam int TMP_W = REM_W + 2;

  logic             vld_r  [R_W];
  logic [REM_W-1:0] rem_r  [R_W];
  logic [R_W-1:0]   root_r [R_W];
  logic [N_W-1:0]   low_r  [R_W];
  logic [S_W-1:0]   side_r [R_W];

  logic             vld_nxt  [R_W];
  logic [REM_W-1:0] rem_nxt  [R_W];
  logic [R_W-1:0]   root_nxt [R_W];
  logic [N_W-1:0]   low_nxt  [R_W];
  logic [S_W-1:0]   side_nxt [R_W];

  // bring down two radicand bits, try root*4+1
  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic             vld_in;
    logic [REM_W-1:0] rem_in;
    logic [R_W-1:0]   root_in;
    logic [N_W-1:0]   low_in;
    logic [S_W-1:0]   side_in;
    logic [TMP_W-1:0] tmp;
    logic [TMP_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign low_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign low_in  = low_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign tmp         = {rem_in, low_in[N_W-1:N_W-2]};
    assign trial       = TMP_W'({root_in, 2'b01});
    assign ge          = (tmp >= trial);
    assign vld_nxt[k]  = vld_in;
    assign rem_nxt[k]  = ge ? REM_W'(tmp - trial) : tmp[REM_W-1:0];
    assign root_nxt[k] = {root_in[R_W-2:0], ge};
    assign low_nxt[k]  = {low_in[N_W-3:0], 2'b00};
    assign side_nxt[k] = side_in;
  end

  // valid bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < R_W; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < R_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        low_r[k]  <= low_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[R_W-1];
  assign out_root  = root_r[R_W-1];
  assign out_side  = side_r[R_W-1];

endmodule

`default_nettype wire

FILE: hw/rtl/primary_ray_direction.sv
`default_nettype none

// Pinhole-camera primary ray direction: each item is a pixel coordinate with a
// sixteenth-pixel offset (8 is the pixel center) and yields one unit direction
// in signed Q1.16, components in world space. One item enters per clock
// while the pipeline is not stalled; it is 91 register stages deep, set
// mostly by the 30-stage screen-offset dividers, the 31-stage square root
// and the 17-stage normalizing dividers. A stall on the result side freezes
// the whole pipeline, so in_stall follows out_stall while a result waits.
// Configuration writes are taken every cycle and must only be made while no
// item is in flight; a zero screen height acts as one, and an all-zero sum
// vector gives an all-zero direction.
module primary_ray_direction (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [prd_pkg::COORD_BITS-1:0] in_pixel_x,
  input  wire logic [prd_pkg::COORD_BITS-1:0] in_pixel_y,
  input  wire logic [prd_pkg::SUB_BITS-1:0]   in_sub_x,
  input  wire logic [prd_pkg::SUB_BITS-1:0]   in_sub_y,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [prd_pkg::CW-1:0]       out_dir_x,
  output logic signed [prd_pkg::CW-1:0]       out_dir_y,
  output logic signed [prd_pkg::CW-1:0]       out_dir_z,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prd_pkg::VEC_W-1:0]      cfg_data
);

  localparam int F       = prd_pkg::FRAC_BITS;
  localparam int CW      = prd_pkg::CW;
  localparam int UX_W    = prd_pkg::COORD_BITS + prd_pkg::SUB_BITS;
  localparam int NUM_W   = UX_W + 2;
  localparam int PROD_W  = 2 * NUM_W;
  localparam int DEN_W   = prd_pkg::DIM_BITS + 3;
  localparam int DN_W    = UX_W + prd_pkg::TAN_W + 1;
  localparam int OFS_W   = F + 14;
  localparam int MP_W    = OFS_W + 1 + CW;
  localparam int TERM_W  = MP_W - F;
  localparam int SUM_W   = TERM_W + 2;
  localparam int MAG_W   = SUM_W - 1;
  localparam int NRM_W   = prd_pkg::NORM_BIT + 1;
  localparam int SQ_W    = 2 * NRM_W;
  localparam int FN_W    = NRM_W + F;
  localparam int FQ_W    = F + 1;
  localparam int SIDE_W  = 1 + 3 + 3 * NRM_W;
  localparam int RSH_W   = 3;
  localparam int LSH_W   = 5;

  // configuration registers
  logic [prd_pkg::DIM_BITS-1:0] width_r;
  logic [prd_pkg::DIM_BITS-1:0] height_r;
  logic [prd_pkg::TAN_W-1:0]    tan_r;
  logic [prd_pkg::VEC_W-1:0]    right_r;
  logic [prd_pkg::VEC_W-1:0]    up_r;
  logic [prd_pkg::VEC_W-1:0]    front_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= prd_pkg::DIM_BITS'(1);
      height_r <= prd_pkg::DIM_BITS'(1);
      tan_r    <= prd_pkg::TAN_W'(1) << F;
      right_r  <= '0;
      up_r     <= '0;
      front_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (prd_pkg::cfg_reg_t'(cfg_index))
        prd_pkg::REG_WIDTH:  width_r  <= cfg_data[prd_pkg::DIM_BITS-1:0];
        prd_pkg::REG_HEIGHT: height_r <= cfg_data[prd_pkg::DIM_BITS-1:0];
        prd_pkg::REG_TAN:    tan_r    <= cfg_data[prd_pkg::TAN_W-1:0];
        prd_pkg::REG_RIGHT:  right_r  <= cfg_data;
        prd_pkg::REG_UP:     up_r     <= cfg_data;
        prd_pkg::REG_FRONT:  front_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a finished result is held
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic [prd_pkg::DIM_BITS-1:0] h_eff;
  assign h_eff = (height_r == '0) ? prd_pkg::DIM_BITS'(1) : height_r;

  // stage 1: screen offset numerators times tan
  logic                     s1_vld_r;
  logic signed [PROD_W-1:0] s1_px_r, s1_py_r;
  logic signed [NUM_W-1:0]  numx, numy, tan_s;
  logic [UX_W-1:0]          ux, uy;

  assign ux    = {in_pixel_x, in_sub_x};
  assign uy    = {in_pixel_y, in_sub_y};
  assign numx  = $signed({2'b00, ux}) - $signed({2'b00, width_r, 3'b000});
  assign numy  = $signed({2'b00, h_eff, 3'b000}) - $signed({2'b00, uy});
  assign tan_s = $signed(NUM_W'(tan_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r <= numx * tan_s;
      s1_py_r <= numy * tan_s;
    end
  end

  // stage 2: magnitude plus half divisor for rounding
  logic             s2_vld_r;
  logic [DN_W-1:0]  s2_nx_r, s2_ny_r;
  logic             s2_negx_r, s2_negy_r;
  logic [DEN_W-1:0] s2_den_r;
  logic [PROD_W-1:0] ax, ay;

  assign ax = s1_px_r[PROD_W-1] ? PROD_W'(-s1_px_r) : PROD_W'(s1_px_r);
  assign ay = s1_py_r[PROD_W-1] ? PROD_W'(-s1_py_r) : PROD_W'(s1_py_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nx_r   <= ax[DN_W-1:0] + DN_W'({h_eff, 2'b00});
      s2_ny_r   <= ay[DN_W-1:0] + DN_W'({h_eff, 2'b00});
      s2_negx_r <= s1_px_r[PROD_W-1];
      s2_negy_r <= s1_py_r[PROD_W-1];
      s2_den_r  <= {h_eff, 3'b000};
    end
  end

  // screen offset dividers; the quotient stays below 2^30, so it fits in OFS_W bits
  logic             dvx_vld, dvy_vld;
  logic [OFS_W-1:0] qx, qy;
  logic             negx, negy;

  prd_div #(.N_W(DN_W), .D_W(DEN_W), .Q_W(OFS_W), .S_W(1)) u_div_x (
    .clk, .rst_n, .en,
    .in_valid (s2_vld_r),
    .in_num   (s2_nx_r),
    .in_den   (s2_den_r),
    .in_side  (s2_negx_r),
    .out_valid(dvx_vld),
    .out_quo  (qx),
    .out_side (negx)
  );

  prd_div #(.N_W(DN_W), .D_W(DEN_W), .Q_W(OFS_W), .S_W(1)) u_div_y (
    .clk, .rst_n, .en,
    .in_valid (s2_vld_r),
    .in_num   (s2_ny_r),
    .in_den   (s2_den_r),
    .in_side  (s2_negy_r),
    .out_valid(dvy_vld),
    .out_quo  (qy),
    .out_side (negy)
  );

  // stage 3: offsets times right and up components
  logic                    s3_vld_r;
  logic signed [MP_W-1:0]  s3_pr_r [3];
  logic signed [MP_W-1:0]  s3_pu_r [3];
  logic signed [OFS_W:0]   pxs, pys;

  assign pxs = negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign pys = negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= dvx_vld && dvy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_pr_r[i] <= pxs * $signed(right_r[i*CW +: CW]);
        s3_pu_r[i] <= pys * $signed(up_r[i*CW +: CW]);
      end
    end
  end

  // stage 4: round products half away from zero to Q.F
  logic                     s4_vld_r;
  logic signed [TERM_W-1:0] s4_a_r [3];
  logic signed [TERM_W-1:0] s4_b_r [3];
  logic signed [TERM_W-1:0] ta [3];
  logic signed [TERM_W-1:0] tb [3];

  always_comb begin
    logic [MP_W-1:0] ma, mb;
    logic [MP_W-1:0] ra, rb;
    for (int i = 0; i < 3; i++) begin
      ma = s3_pr_r[i][MP_W-1] ? MP_W'(-s3_pr_r[i]) : MP_W'(s3_pr_r[i]);
      mb = s3_pu_r[i][MP_W-1] ? MP_W'(-s3_pu_r[i]) : MP_W'(s3_pu_r[i]);
      ra = ma + (MP_W'(1) << (F - 1));
      rb = mb + (MP_W'(1) << (F - 1));
      ta[i] = s3_pr_r[i][MP_W-1] ? -$signed({1'b0, ra[MP_W-2:F]})
                                 : $signed({1'b0, ra[MP_W-2:F]});
      tb[i] = s3_pu_r[i][MP_W-1] ? -$signed({1'b0, rb[MP_W-2:F]})
                                 : $signed({1'b0, rb[MP_W-2:F]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_a_r[i] <= ta[i];
        s4_b_r[i] <= tb[i];
      end
    end
  end

  // stage 5: sum with the front vector
  logic                    s5_vld_r;
  logic signed [SUM_W-1:0] s5_sum_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_sum_r[i] <= SUM_W'(s4_a_r[i]) + SUM_W'(s4_b_r[i])
                     + SUM_W'($signed(front_r[i*CW +: CW]));
      end
    end
  end

  // stage 6: sign and magnitude
  logic             s6_vld_r;
  logic [MAG_W-1:0] s6_mag_r [3];
  logic [2:0]       s6_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_neg_r[i] <= s5_sum_r[i][SUM_W-1];
        s6_mag_r[i] <= s5_sum_r[i][SUM_W-1] ? MAG_W'(-s5_sum_r[i])
                                            : MAG_W'(s5_sum_r[i]);
      end
    end
  end

  // stage 7: largest magnitude
  logic             s7_vld_r;
  logic [MAG_W-1:0] s7_mag_r [3];
  logic [2:0]       s7_neg_r;
  logic [MAG_W-1:0] s7_mx_r;
  logic [MAG_W-1:0] mx01;

  assign mx01 = (s6_mag_r[0] > s6_mag_r[1]) ? s6_mag_r[0] : s6_mag_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_mag_r <= s6_mag_r;
      s7_neg_r <= s6_neg_r;
      s7_mx_r  <= (mx01 > s6_mag_r[2]) ? mx01 : s6_mag_r[2];
    end
  end

  // stage 8: pick the rescaling shift
  logic             s8_vld_r;
  logic [MAG_W-1:0] s8_mag_r [3];
  logic [2:0]       s8_neg_r;
  logic             s8_zero_r;
  logic [RSH_W-1:0] s8_rsh_r;
  logic [LSH_W-1:0] s8_lsh_r;
  logic [RSH_W-1:0] rsh;
  logic [LSH_W-1:0] lsh;

  // right shift rounds up; a top value of exactly 2^(30+k) stops at 2^30
  always_comb begin
    if (s7_mx_r < (MAG_W'(1) << prd_pkg::NORM_BIT)) begin
      rsh = RSH_W'(0);
    end else if (s7_mx_r <= (MAG_W'(1) << (prd_pkg::NORM_BIT + 1))) begin
      rsh = RSH_W'(1);
    end else if (s7_mx_r <= (MAG_W'(1) << (prd_pkg::NORM_BIT + 2))) begin
      rsh = RSH_W'(2);
    end else if (s7_mx_r <= (MAG_W'(1) << (prd_pkg::NORM_BIT + 3))) begin
      rsh = RSH_W'(3);
    end else begin
      rsh = RSH_W'(4);
    end
  end

  // left shift brings the top bit up to bit 29
  always_comb begin
    lsh = '0;
    for (int j = 0; j < prd_pkg::NORM_BIT - 1; j++) begin
      if (s7_mx_r[j]) begin
        lsh = LSH_W'(prd_pkg::NORM_BIT - 1 - j);
      end
    end
    if (s7_mx_r >= (MAG_W'(1) << (prd_pkg::NORM_BIT - 1))) begin
      lsh = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_mag_r  <= s7_mag_r;
      s8_neg_r  <= s7_neg_r;
      s8_zero_r <= (s7_mx_r == '0);
      s8_rsh_r  <= rsh;
      s8_lsh_r  <= lsh;
    end
  end

  // stage 9: apply the shift
  logic             s9_vld_r;
  logic [NRM_W-1:0] s9_mag_r [3];
  logic [2:0]       s9_neg_r;
  logic             s9_zero_r;
  logic [NRM_W-1:0] nmag [3];

  always_comb begin
    logic [MAG_W:0] up_v;
    logic [MAG_W:0] rnd;
    for (int i = 0; i < 3; i++) begin
      rnd  = (MAG_W+1)'(s8_mag_r[i]) + (((MAG_W+1)'(1) << s8_rsh_r) - (MAG_W+1)'(1));
      up_v = (MAG_W+1)'(s8_mag_r[i]) << s8_lsh_r;
      nmag[i] = (s8_rsh_r != '0) ? NRM_W'(rnd >> s8_rsh_r) : up_v[NRM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else if (en) begin
      s9_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_mag_r  <= nmag;
      s9_neg_r  <= s8_neg_r;
      s9_zero_r <= s8_zero_r;
    end
  end

  // stage 10: squares
  logic              s10_vld_r;
  logic [NRM_W-1:0]  s10_mag_r [3];
  logic [2:0]        s10_neg_r;
  logic              s10_zero_r;
  logic [SQ_W-1:0]   s10_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_vld_r <= 1'b0;
    end else if (en) begin
      s10_vld_r <= s9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_mag_r  <= s9_mag_r;
      s10_neg_r  <= s9_neg_r;
      s10_zero_r <= s9_zero_r;
      for (int i = 0; i < 3; i++) begin
        s10_sq_r[i] <= SQ_W'(s9_mag_r[i]) * SQ_W'(s9_mag_r[i]);
      end
    end
  end

  // stage 11: sum of squares, below 2^62
  logic              s11_vld_r;
  logic [SIDE_W-1:0] s11_side_r;
  logic [SQ_W-1:0]   s11_ss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_vld_r <= 1'b0;
    end else if (en) begin
      s11_vld_r <= s10_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_ss_r   <= s10_sq_r[0] + s10_sq_r[1] + s10_sq_r[2];
      s11_side_r <= {s10_zero_r, s10_neg_r, s10_mag_r[2], s10_mag_r[1], s10_mag_r[0]};
    end
  end

  // vector length
  logic              sq_vld;
  logic [NRM_W-1:0]  root;
  logic [SIDE_W-1:0] sq_side;

  prd_sqrt #(.N_W(SQ_W), .S_W(SIDE_W)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (s11_vld_r),
    .in_rad   (s11_ss_r),
    .in_side  (s11_side_r),
    .out_valid(sq_vld),
    .out_root (root),
    .out_side (sq_side)
  );

  // stage 12: scaled numerators with half the length for rounding
  logic             s12_vld_r;
  logic [FN_W-1:0]  s12_num_r [3];
  logic [NRM_W-1:0] s12_den_r;
  logic [2:0]       s12_neg_r;
  logic             s12_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s12_vld_r <= 1'b0;
    end else if (en) begin
      s12_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s12_num_r[i] <= {sq_side[i*NRM_W +: NRM_W], F'(0)} + FN_W'(root >> 1);
      end
      s12_den_r  <= (root == '0) ? NRM_W'(1) : root;
      s12_neg_r  <= sq_side[3*NRM_W +: 3];
      s12_zero_r <= sq_side[SIDE_W-1];
    end
  end

  // normalizing dividers
  logic            fx_vld, fy_vld, fz_vld;
  logic [FQ_W-1:0] fqx, fqy, fqz;
  logic            fnx, fny, fnz, fzero;

  prd_div #(.N_W(FN_W), .D_W(NRM_W), .Q_W(FQ_W), .S_W(2)) u_ndiv_x (
    .clk, .rst_n, .en,
    .in_valid (s12_vld_r),
    .in_num   (s12_num_r[0]),
    .in_den   (s12_den_r),
    .in_side  ({s12_zero_r, s12_neg_r[0]}),
    .out_valid(fx_vld),
    .out_quo  (fqx),
    .out_side ({fzero, fnx})
  );

  prd_div #(.N_W(FN_W), .D_W(NRM_W), .Q_W(FQ_W), .S_W(1)) u_ndiv_y (
    .clk, .rst_n, .en,
    .in_valid (s12_vld_r),
    .in_num   (s12_num_r[1]),
    .in_den   (s12_den_r),
    .in_side  (s12_neg_r[1]),
    .out_valid(fy_vld),
    .out_quo  (fqy),
    .out_side (fny)
  );

  prd_div #(.N_W(FN_W), .D_W(NRM_W), .Q_W(FQ_W), .S_W(1)) u_ndiv_z (
    .clk, .rst_n, .en,
    .in_valid (s12_vld_r),
    .in_num   (s12_num_r[2]),
    .in_den   (s12_den_r),
    .in_side  (s12_neg_r[2]),
    .out_valid(fz_vld),
    .out_quo  (fqz),
    .out_side (fnz)
  );

  // output register
  logic signed [CW-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic signed [CW-1:0] dir_x_nxt, dir_y_nxt, dir_z_nxt;

  assign dir_x_nxt = fzero ? '0 : (fnx ? -$signed({1'b0, fqx}) : $signed({1'b0, fqx}));
  assign dir_y_nxt = fzero ? '0 : (fny ? -$signed({1'b0, fqy}) : $signed({1'b0, fqy}));
  assign dir_z_nxt = fzero ? '0 : (fnz ? -$signed({1'b0, fqz}) : $signed({1'b0, fqz}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fx_vld && fy_vld && fz_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_x_r <= dir_x_nxt;
      dir_y_r <= dir_y_nxt;
      dir_z_r <= dir_z_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dir_x = dir_x_r;
  assign out_dir_y = dir_y_r;
  assign out_dir_z = dir_z_r;

`ifndef ASSERT_OFF
  // a unit vector never has a component beyond one
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= 18'sd65536 && out_dir_x >= -18'sd65536 &&
                   out_dir_y <= 18'sd65536 && out_dir_y >= -18'sd65536 &&
                   out_dir_z <= 18'sd65536 && out_dir_z >= -18'sd65536))
    else $error("ray direction component out of range");

  // input side only waits on a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an all-zero sum vector leaves the divider as an all-zero direction
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (en && fx_vld && fzero) |=> (out_dir_x == '0 && out_dir_y == '0 && out_dir_z == '0))
    else $error("zero sum vector gave a nonzero direction");
`endif

endmodule

`default_nettype wire
